// File: src/qhp_pkg.sv
// shared types and defaults for the quicksort hoare partition sorter
// used by qhp_ctrl, qhp_dp and quicksort_hoare_partition_top; no dependencies
`default_nettype none

package qhp_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SORT_START,
    S_POP,
    S_POP_WAIT,
    S_PART_START,
    S_PIV_LOAD,
    S_LSCAN_RD,
    S_LSCAN_CMP,
    S_RSCAN_RD,
    S_RSCAN_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_PUSH_R,
    S_PUSH_L,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // element store read address source
  typedef enum logic [1:0] {
    RD_LO,
    RD_I,
    RD_J,
    RD_K
  } rd_sel_t;

  typedef struct packed {
    logic    load_wr;     // store input word at fill position
    logic    clr_run;     // clear fill count and overflow flag
    logic    range_init;  // range = whole set
    logic    pop;         // pop a range off the stack
    logic    range_ld;    // range from stack read data
    logic    part_init;   // left/right scan start at range ends
    logic    piv_ld;      // pivot from read data
    rd_sel_t rd_sel;
    logic    cap_l;       // hold left scan word
    logic    cap_r;       // hold right scan word
    logic    inc_i;
    logic    dec_j;
    logic    wr_l;        // store[i] = right word
    logic    wr_r;        // store[j] = left word
    logic    push_hi;     // push upper part (guarded)
    logic    push_lo;     // push lower part (guarded)
    logic    emit_init;
    logic    emit_ld;     // load output register, advance emit index
  } cmd_t;

  typedef struct packed {
    logic count_gt1;
    logic sp_zero;
    logic l_less;     // read word < pivot
    logic r_greater;  // pivot < read word
    logic i_lt_hi;
    logic j_gt_lo;
    logic i_ge_j;
    logic i_in_rng;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

// File: src/quicksort_hoare_partition_top.sv
// top level of the quicksort sorter: stream ports, controller and datapath
// depends on qhp_pkg, qhp_ctrl and qhp_dp
`default_nettype none

// Collects signed words one per cycle until a word marked tlast, then sorts
// them ascending in place with quicksort (Hoare partition, first element of
// each range as pivot, explicit stack of index ranges) and streams them out,
// tlast on the final sorted word and tuser set on every word of the run if
// words beyond DEPTH were dropped. The tlast word still starts the sort when
// it is dropped. The input is held off from the tlast word until the last
// sorted word has entered the output register. Sorting runs through one
// element store port pair (one write, one registered read): each scan step
// reads a word and then compares it with the pivot, each swap writes the two
// words one after the other, and set-up and stack handling come around each
// partition. When emitting, each word is read from the store and then loaded
// into the output register once that register is free.

module quicksort_hoare_partition_top
  import qhp_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int TW        = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [TW-1:0] in_tdata,   // value
  input  wire logic          in_tlast,   // last
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [TW-1:0]      out_tdata,  // value_res
  output logic               out_tlast,  // last_res
  output logic               out_tuser   // overflow
);

  cmd_t                  cmd;
  sts_t                  sts;
  state_t                state;
  logic [DATA_WIDTH-1:0] out_value;

  qhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  qhp_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (in_tdata[DATA_WIDTH-1:0]),
    .out_value (out_value),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  // word is zero-padded up to whole bytes
  assign out_tdata = TW'(out_value);

  // the range stack must be empty when a new sort begins
  a_stack_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_SORT_START) |-> sts.sp_zero)
    else $error("range stack not empty at sort start");

  // the left scan never leaves the current range
  a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_LSCAN_CMP) |-> sts.i_in_rng)
    else $error("left scan index outside range");

  // a word handed to a free output register shows up as valid
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_EMIT_LD && sts.out_free) |=> out_tvalid)
    else $error("emitted word not presented");

endmodule

`default_nettype wire

// File: src/qhp_ctrl.sv
// sequencing state machine for load, partition, stack handling and emit
// depends on qhp_pkg; drives qhp_dp through cmd_t, reads back sts_t
`default_nettype none

module qhp_ctrl
  import qhp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_tvalid,
  input  wire logic   in_tlast,
  output logic        in_tready,
  input  wire sts_t   sts,
  output cmd_t        cmd,
  output state_t      state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_I;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_wr = 1'b1;
          if (in_tlast) state_nxt = S_SORT_START;
        end
      end
      S_SORT_START: begin
        if (sts.count_gt1) begin
          cmd.range_init = 1'b1;
          state_nxt      = S_PART_START;
        end else begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.range_ld = 1'b1;
        state_nxt    = S_PART_START;
      end
      S_PART_START: begin
        cmd.rd_sel    = RD_LO;
        cmd.part_init = 1'b1;
        state_nxt     = S_PIV_LOAD;
      end
      S_PIV_LOAD: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = S_LSCAN_RD;
      end
      S_LSCAN_RD: begin
        state_nxt = S_LSCAN_CMP;
      end
      S_LSCAN_CMP: begin
        cmd.cap_l = 1'b1;
        if (sts.l_less && sts.i_lt_hi) begin
          cmd.inc_i = 1'b1;
          state_nxt = S_LSCAN_RD;
        end else begin
          state_nxt = S_RSCAN_RD;
        end
      end
      S_RSCAN_RD: begin
        cmd.rd_sel = RD_J;
        state_nxt  = S_RSCAN_CMP;
      end
      S_RSCAN_CMP: begin
        cmd.rd_sel = RD_J;
        cmd.cap_r  = 1'b1;
        if (sts.r_greater && sts.j_gt_lo) begin
          cmd.dec_j = 1'b1;
          state_nxt = S_RSCAN_RD;
        end else if (sts.i_ge_j) begin
          state_nxt = S_PUSH_R;
        end else begin
          state_nxt = S_SWAP_A;
        end
      end
      S_SWAP_A: begin
        cmd.wr_l  = 1'b1;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.wr_r  = 1'b1;
        cmd.inc_i = 1'b1;
        cmd.dec_j = 1'b1;
        state_nxt = S_LSCAN_RD;
      end
      S_PUSH_R: begin
        cmd.push_hi = 1'b1;
        state_nxt   = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_lo = 1'b1;
        state_nxt   = S_POP;
      end
      S_EMIT_RD: begin
        cmd.rd_sel = RD_K;
        state_nxt  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.rd_sel = RD_K;
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.emit_last) begin
            cmd.clr_run = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign state = state_r;

endmodule

`default_nettype wire

// File: src/qhp_dp.sv
// datapath: element store, range stack, scan indices, pivot, output register
// depends on qhp_pkg; controlled by qhp_ctrl through cmd_t
`default_nettype none

module qhp_dp
  import qhp_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  output logic [DATA_WIDTH-1:0]      out_value,
  output logic                       out_last,
  output logic                       out_ovf,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // element store, one write and one registered read port
  logic [DATA_WIDTH-1:0] store_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [IW-1:0]         rd_addr;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;

  // range stack, entries {lo, hi}
  logic [2*IW-1:0] stk_mem [DEPTH];
  logic [2*IW-1:0] stk_rd_r;
  logic [2*IW-1:0] stk_wr_data;
  logic            stk_wr_en;
  logic [CW-1:0]   sp_r, sp_nxt;
  logic [CW-1:0]   sp_m1;

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         count_m1;
  logic                  ovf_r, ovf_nxt;
  logic [IW-1:0]         lo_r, lo_nxt;
  logic [IW-1:0]         hi_r, hi_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         j_r, j_nxt;
  logic [IW-1:0]         k_r, k_nxt;
  logic [DATA_WIDTH-1:0] piv_r;
  logic [DATA_WIDTH-1:0] lval_r;
  logic [DATA_WIDTH-1:0] rval_r;
  logic [DATA_WIDTH-1:0] oval_r;
  logic                  olast_r;
  logic                  oovf_r;
  logic                  ovalid_r, ovalid_nxt;
  logic [IW:0]           j_p1;
  logic                  stk_room;
  logic                  full;

  assign count_m1 = count_r - 1'b1;
  assign sp_m1    = sp_r - 1'b1;
  assign j_p1     = {1'b0, j_r} + 1'b1;
  assign stk_room = (sp_r < CW'(DEPTH));
  assign full     = (count_r == CW'(DEPTH));

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = lo_r;
      RD_I:    rd_addr = i_r;
      RD_J:    rd_addr = j_r;
      RD_K:    rd_addr = k_r;
      default: rd_addr = i_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IW-1:0];
    wr_data = in_value;
    if (cmd.load_wr && !full) begin
      wr_en = 1'b1;
    end else if (cmd.wr_l) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_data = rval_r;
    end else if (cmd.wr_r) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = lval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_data = {j_p1[IW-1:0], hi_r};
    if (cmd.push_hi && (j_p1 < {1'b0, hi_r}) && stk_room) begin
      stk_wr_en = 1'b1;
    end else if (cmd.push_lo && (lo_r < j_r) && stk_room) begin
      stk_wr_en   = 1'b1;
      stk_wr_data = {lo_r, j_r};
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) stk_mem[sp_r[IW-1:0]] <= stk_wr_data;
    stk_rd_r <= stk_mem[sp_m1[IW-1:0]];
  end

  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    sp_nxt     = sp_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    ovalid_nxt = ovalid_r;
    if (cmd.load_wr) begin
      if (full) ovf_nxt = 1'b1;
      else      count_nxt = count_r + 1'b1;
    end
    if (cmd.clr_run) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
    if (cmd.range_init) begin
      lo_nxt = '0;
      hi_nxt = count_m1[IW-1:0];
    end
    if (cmd.range_ld) begin
      lo_nxt = stk_rd_r[2*IW-1:IW];
      hi_nxt = stk_rd_r[IW-1:0];
    end
    if (cmd.pop) sp_nxt = sp_m1;
    if (stk_wr_en) sp_nxt = sp_r + 1'b1;
    if (cmd.part_init) begin
      i_nxt = lo_r;
      j_nxt = hi_r;
    end
    if (cmd.inc_i) i_nxt = i_r + 1'b1;
    if (cmd.dec_j) j_nxt = j_r - 1'b1;
    if (cmd.emit_init) k_nxt = '0;
    if (cmd.emit_ld) k_nxt = k_r + 1'b1;
    if (cmd.emit_ld)     ovalid_nxt = 1'b1;
    else if (out_ready)  ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      sp_r     <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      sp_r     <= sp_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.piv_ld) piv_r  <= rd_data_r;
    if (cmd.cap_l)  lval_r <= rd_data_r;
    if (cmd.cap_r)  rval_r <= rd_data_r;
    if (cmd.emit_ld) begin
      oval_r  <= rd_data_r;
      olast_r <= (k_r == count_m1[IW-1:0]);
      oovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.count_gt1 = (count_r > CW'(1));
    sts.sp_zero   = (sp_r == '0);
    sts.l_less    = ($signed(rd_data_r) < $signed(piv_r));
    sts.r_greater = ($signed(piv_r) < $signed(rd_data_r));
    sts.i_lt_hi   = (i_r < hi_r);
    sts.j_gt_lo   = (j_r > lo_r);
    sts.i_ge_j    = (i_r >= j_r);
    sts.i_in_rng  = (i_r >= lo_r) && (i_r <= hi_r);
    sts.out_free  = !ovalid_r || out_ready;
    sts.emit_last = (k_r == count_m1[IW-1:0]);
  end

  assign out_value = oval_r;
  assign out_last  = olast_r;
  assign out_ovf   = oovf_r;
  assign out_valid = ovalid_r;

endmodule

`default_nettype wire
